@@ rtl/lcs_pkg.sv @@
package lcs_pkg;

   localparam int HISTORY_DEPTH = 16;

   localparam int MA_W     = 5;
   localparam int CFG_W    = 24;
   localparam int VAL_W    = 32;
   localparam int COUNT_W  = 5;
   localparam int SLOT_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W    = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W    = VAL_W + SLOT_W;
   localparam int REM_W    = CNT_W + 1;
   localparam int STEP_W   = $clog2(SUM_W + 1);
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_RANGE_LOW  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_HIGH = 1'd1;

   localparam logic signed [CFG_W-1:0] RANGE_LOW_RESET  = 24'sd0;
   localparam logic signed [CFG_W-1:0] RANGE_HIGH_RESET = 24'sd25600;

   typedef struct packed {
      logic capture;
      logic mul;
      logic scale;
      logic update;
      logic div_start;
      logic div_step;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctrl_status_type;

endpackage

@@ rtl/lcs_stream_if.sv @@
interface lcs_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] current_ma;

   modport source (output valid, output current_ma, input ready);
   modport sink   (input valid, input current_ma, output ready);
endinterface

interface lcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] scaled_value;
   logic [31:0] history_mean;
   logic [4:0]  valid_count;

   modport source (output valid, output scaled_value, output history_mean,
                   output valid_count, input ready);
   modport sink   (input valid, input scaled_value, input history_mean,
                   input valid_count, output ready);
endinterface

@@ rtl/lcs_ctrl.sv @@
module lcs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lcs_pkg::ctrl_status_type status,
   output lcs_pkg::ctrl_cmd_type    cmd
);
   import lcs_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_SCALE = 3'd2;
   localparam logic [2:0] S_UPD   = 3'd3;
   localparam logic [2:0] S_PREP  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_PREP;
         end
         S_PREP: begin
            cmd.div_start = 1'b1;
            step_in       = '0;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ rtl/lcs_datapath.sv @@
module lcs_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [lcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lcs_pkg::CFG_W-1:0]     csr_write_data,
   input  logic [lcs_pkg::MA_W-1:0]      req_current_ma,
   input  lcs_pkg::ctrl_cmd_type         cmd,
   output lcs_pkg::ctrl_status_type      status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lcs_pkg::VAL_W-1:0]     rsp_scaled_value,
   output logic [lcs_pkg::VAL_W-1:0]     rsp_history_mean,
   output logic [lcs_pkg::COUNT_W-1:0]   rsp_valid_count
);
   import lcs_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

   // configuration
   logic signed [CFG_W-1:0] range_low_ff, range_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_RANGE_LOW:  range_low_ff  <= csr_write_data;
            REG_RANGE_HIGH: range_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // scaling
   logic [MA_W-1:0]         ma_ff;
   logic signed [CFG_W:0]   span_ff;
   logic signed [MA_W:0]    offset;
   logic signed [30:0]      prod_ff, prod_in;
   logic signed [30:0]      prod_bias;
   logic signed [26:0]      quot16;
   logic signed [VAL_W-1:0] val_ff, val_in;

   assign offset    = $signed({1'b0, ma_ff}) - 6'sd4;
   assign prod_in   = 31'(offset) * 31'(span_ff);
   assign prod_bias = prod_ff + (prod_ff[30] ? 31'sd15 : 31'sd0);
   assign quot16    = prod_bias[30:4];
   assign val_in    = (ma_ff == '0) ? '0 :
                      (VAL_W'(quot16) + VAL_W'(range_low_ff));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ma_ff   <= req_current_ma;
         span_ff <= (CFG_W+1)'(range_high_ff) - (CFG_W+1)'(range_low_ff);
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.scale) begin
         val_ff <= val_in;
      end
   end

   // history
   logic [VAL_W-1:0]         hist_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] hist_valid_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic [VAL_W-1:0]         old_ff;
   logic                     old_valid_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         count_ff;
   logic signed [SUM_W-1:0]  old_ext, val_ext;

   assign old_ext = old_valid_ff ? SUM_W'($signed(old_ff)) : '0;
   assign val_ext = SUM_W'(val_ff);
   assign sum_in  = sum_ff - old_ext + val_ext;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         old_ff <= hist_mem[slot_ff];
      end
      if (cmd.update) begin
         hist_mem[slot_ff] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= '0;
         slot_ff       <= '0;
         sum_ff        <= '0;
         count_ff      <= '0;
         old_valid_ff  <= 1'b0;
      end else begin
         if (cmd.mul) begin
            old_valid_ff <= hist_valid_ff[slot_ff];
         end
         if (cmd.update) begin
            hist_valid_ff[slot_ff] <= 1'b1;
            sum_ff                 <= sum_in;
            if (!old_valid_ff) begin
               count_ff <= count_ff + 1'b1;
            end
            slot_ff <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         end
      end
   end

   // restoring divide of |sum| by count, one bit per beat of the step counter
   logic [SUM_W-1:0] quo_ff;
   logic [REM_W-1:0] rem_ff;
   logic             neg_ff;
   logic [REM_W-1:0] rem_shift;
   logic             rem_ge;
   logic [SUM_W-1:0] mean_full;

   assign rem_shift = {rem_ff[REM_W-2:0], quo_ff[SUM_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, count_ff});
   assign mean_full = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= sum_ff[SUM_W-1];
         quo_ff <= sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], rem_ge};
         rem_ff <= rem_ge ? (rem_shift - {1'b0, count_ff}) : rem_shift;
      end
   end

   // output register
   logic                out_valid_ff;
   logic [VAL_W-1:0]    out_scaled_ff, out_mean_ff;
   logic [COUNT_W-1:0]  out_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_scaled_ff <= val_ff;
         out_mean_ff   <= mean_full[VAL_W-1:0];
         out_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign status.out_free  = !out_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_scaled_value = out_scaled_ff;
   assign rsp_history_mean = out_mean_ff;
   assign rsp_valid_count  = out_count_ff;

endmodule

@@ rtl/loop_current_scaler_with_history_mean_unit.sv @@
// Each request runs capture, multiply, scale, history update, divider prep, the 36-step
// restoring divider for the mean and the output load; only one request is in flight at a time.
// The next request is taken once the response is loaded; a held response stalls its final load.
// Reset (synchronous, active high) clears the history valid bits, sum, count, slot,
// range registers (low 0, high 25600) and the output valid flag; stored values are not cleared.
module loop_current_scaler_with_history_mean_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [lcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lcs_pkg::CFG_W-1:0]     csr_write_data,
   lcs_req_if.sink                       req_if,
   lcs_rsp_if.source                     rsp_if
);
   import lcs_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   lcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lcs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_current_ma   (req_if.current_ma),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_scaled_value (rsp_if.scaled_value),
      .rsp_history_mean (rsp_if.history_mean),
      .rsp_valid_count  (rsp_if.valid_count)
   );

endmodule
